// ----- rtl/blg_pkg.sv -----
// Shared constants, widths and cell-curve tables for the battery level gauge.
package blg_pkg;

    localparam int MV_W         = 13;
    localparam int LVL_W        = 7;
    localparam int PCT_W        = 7;
    localparam int MV_MAX       = (1 << MV_W) - 1;

    localparam int RING_DEPTH   = 12;
    localparam int CURVE_POINTS = 23;

    localparam int IDX_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int CIDX_W = $clog2(CURVE_POINTS);

    localparam int Q_FRAC  = 8;
    localparam int FULL_Q8 = 100 << Q_FRAC;
    localparam int Q_W     = $clog2(FULL_Q8 + 1);
    localparam int LVL_MAX = 100;

    localparam int LOW_MARK_RST  = 3300;
    localparam int HIGH_MARK_RST = 4260;

    localparam int SUM_W = $clog2(RING_DEPTH * MV_MAX + RING_DEPTH / 2 + 1);
    localparam int DEN_W = MV_W;

    // The rounded ring average divides by 12 as a shift by 2 followed by a
    // multiply with the reciprocal of 3, which is exact below 2^17.
    localparam int AVG_PRE_SHIFT   = 2;
    localparam int AVG_RECIP       = 43691;
    localparam int AVG_RECIP_W     = 16;
    localparam int AVG_RECIP_SHIFT = 17;
    localparam int AVG_Y_W         = SUM_W - AVG_PRE_SHIFT;
    localparam int AVG_P_W         = AVG_Y_W + AVG_RECIP_W;

    function automatic logic [MV_W-1:0] curve_mv(input logic [CIDX_W-1:0] idx);
        logic [MV_W-1:0] v;
        case (idx)
            5'd0:    v = 13'd3270;
            5'd1:    v = 13'd3610;
            5'd2:    v = 13'd3690;
            5'd3:    v = 13'd3710;
            5'd4:    v = 13'd3730;
            5'd5:    v = 13'd3750;
            5'd6:    v = 13'd3770;
            5'd7:    v = 13'd3790;
            5'd8:    v = 13'd3800;
            5'd9:    v = 13'd3820;
            5'd10:   v = 13'd3840;
            5'd11:   v = 13'd3850;
            5'd12:   v = 13'd3870;
            5'd13:   v = 13'd3910;
            5'd14:   v = 13'd3950;
            5'd15:   v = 13'd3980;
            5'd16:   v = 13'd4020;
            5'd17:   v = 13'd4080;
            5'd18:   v = 13'd4110;
            5'd19:   v = 13'd4150;
            5'd20:   v = 13'd4200;
            5'd21:   v = 13'd4230;
            5'd22:   v = 13'd4260;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [PCT_W-1:0] curve_pct(input logic [CIDX_W-1:0] idx);
        logic [PCT_W-1:0] p;
        case (idx)
            5'd0:    p = 7'd0;
            5'd1:    p = 7'd5;
            5'd2:    p = 7'd10;
            5'd3:    p = 7'd15;
            5'd4:    p = 7'd20;
            5'd5:    p = 7'd25;
            5'd6:    p = 7'd30;
            5'd7:    p = 7'd35;
            5'd8:    p = 7'd40;
            5'd9:    p = 7'd45;
            5'd10:   p = 7'd50;
            5'd11:   p = 7'd55;
            5'd12:   p = 7'd60;
            5'd13:   p = 7'd65;
            5'd14:   p = 7'd70;
            5'd15:   p = 7'd75;
            5'd16:   p = 7'd80;
            5'd17:   p = 7'd85;
            5'd18:   p = 7'd90;
            5'd19:   p = 7'd95;
            5'd20:   p = 7'd98;
            5'd21:   p = 7'd99;
            5'd22:   p = 7'd100;
            default: p = '0;
        endcase
        return p;
    endfunction

    // An upper bound on the rounded dividend that any curve segment can produce.
    function automatic int curve_num_max();
        int m;
        int span;
        int dp;
        int n;
        m = 0;
        for (int i = 0; i < CURVE_POINTS - 1; i++) begin
            span = int'(curve_mv(CIDX_W'(i + 1))) - int'(curve_mv(CIDX_W'(i)));
            dp   = int'(curve_pct(CIDX_W'(i + 1))) - int'(curve_pct(CIDX_W'(i)));
            if (dp < 0) begin
                dp = 0;
            end
            n = span * dp * (1 << Q_FRAC) + span / 2;
            if (n > m) begin
                m = n;
            end
        end
        return m;
    endfunction

    localparam int AVG_N   = SUM_W;
    localparam int CURVE_N = $clog2(curve_num_max() + 1);
    localparam int LEARN_N = $clog2(MV_MAX * FULL_Q8 + MV_MAX / 2 + 1);
    localparam int NUM_W   = (LEARN_N > AVG_N) ?
                             ((LEARN_N > CURVE_N) ? LEARN_N : CURVE_N) :
                             ((AVG_N > CURVE_N) ? AVG_N : CURVE_N);
    localparam int DCNT_W  = $clog2(NUM_W + 1);

    // Level is (7 * curve + 3 * learned + 1280) / 2560, done as a shift by 9
    // followed by a multiply with the reciprocal of 5.
    localparam int CURVE_WEIGHT = 7;
    localparam int LEARN_WEIGHT = 3;
    localparam int LEVEL_HALF   = 1280;
    localparam int LEVEL_SHIFT  = 9;
    localparam int RECIP_MUL    = 205;
    localparam int RECIP_W      = 8;
    localparam int RECIP_SHIFT  = 10;
    localparam int BLEND_W =
        $clog2((CURVE_WEIGHT + LEARN_WEIGHT) * FULL_Q8 + LEVEL_HALF + 1);
    localparam int T_W = BLEND_W - LEVEL_SHIFT;
    localparam int P_W = T_W + RECIP_W;

endpackage

// ----- rtl/battery_level_gauge.sv -----
// Battery level gauge top level: sample ring, sequencer and shared divider.
//
// Input channel: i_valid / o_ready carry one voltage word, i_voltage_mv in mV,
// per report tick. Output channel: o_valid / i_ready carry one result word:
// blended level in whole percent, the reported voltage, the learned minimum
// and maximum and a flag for each one that moved.
// The first word after reset is reported directly. Every word is stored in
// a 12-entry ring, and later words give no result until the ring has filled
// once; then each word gives one result built from the rounded ring average.
// The block takes one word at a time. The curve segment and the learned
// percent each run the bit-serial divider, one quotient bit a cycle; the
// average adds a sum over the ring entries and a reciprocal multiply, and
// a report may also wait for the output register.
// A finished result sits in the output register; a new word is accepted
// while it waits, and the sequencer holds its next result until i_ready
// frees the register.
// Reset clears the sequencer, the ring pointer and fill flag, and puts the
// learned minimum and maximum at 3300 mV and 4260 mV. Ring contents are not
// cleared; they are only read after every entry has been written.
module battery_level_gauge (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [blg_pkg::MV_W-1:0] i_voltage_mv,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [blg_pkg::LVL_W-1:0] o_level_percent,
    output logic [blg_pkg::MV_W-1:0] o_reported_mv,
    output logic                     o_min_updated,
    output logic                     o_max_updated,
    output logic [blg_pkg::MV_W-1:0] o_learned_min_mv,
    output logic [blg_pkg::MV_W-1:0] o_learned_max_mv
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SUM   = 4'd1;
    localparam logic [3:0] S_AVG   = 4'd2;
    localparam logic [3:0] S_MARK  = 4'd3;
    localparam logic [3:0] S_CLOAD = 4'd4;
    localparam logic [3:0] S_CDIV  = 4'd5;
    localparam logic [3:0] S_LLOAD = 4'd6;
    localparam logic [3:0] S_LDIV  = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    localparam int MV_W    = blg_pkg::MV_W;
    localparam int LVL_W   = blg_pkg::LVL_W;
    localparam int PCT_W   = blg_pkg::PCT_W;
    localparam int IDX_W   = blg_pkg::IDX_W;
    localparam int CNT_W   = blg_pkg::CNT_W;
    localparam int CIDX_W  = blg_pkg::CIDX_W;
    localparam int Q_W     = blg_pkg::Q_W;
    localparam int SUM_W   = blg_pkg::SUM_W;
    localparam int DEN_W   = blg_pkg::DEN_W;
    localparam int NUM_W   = blg_pkg::NUM_W;
    localparam int DCNT_W  = blg_pkg::DCNT_W;
    localparam int BLEND_W = blg_pkg::BLEND_W;
    localparam int T_W     = blg_pkg::T_W;
    localparam int P_W     = blg_pkg::P_W;
    localparam int AVG_Y_W = blg_pkg::AVG_Y_W;
    localparam int AVG_P_W = blg_pkg::AVG_P_W;
    localparam int AVG_Q_W = AVG_P_W - blg_pkg::AVG_RECIP_SHIFT;

    logic [3:0]        r_state;
    logic [MV_W-1:0]   r_ring [blg_pkg::RING_DEPTH];
    logic [MV_W-1:0]   r_rd;
    logic [IDX_W-1:0]  r_slot;
    logic              r_full;
    logic              r_first;
    logic [CNT_W-1:0]  r_cnt;
    logic [SUM_W-1:0]  r_acc;
    logic [MV_W-1:0]   r_rep;
    logic [MV_W-1:0]   r_low;
    logic [MV_W-1:0]   r_high;
    logic              r_min_upd;
    logic              r_max_upd;
    logic [CIDX_W-1:0] r_seg;
    logic [Q_W-1:0]    r_curve;
    logic [Q_W-1:0]    r_learn;
    logic [NUM_W-1:0]  r_dq;
    logic [DEN_W-1:0]  r_dr;
    logic [DEN_W-1:0]  r_dd;
    logic [DCNT_W-1:0] r_dcnt;
    logic              r_o_valid;
    logic [LVL_W-1:0]  r_o_level;
    logic [MV_W-1:0]   r_o_rep;
    logic              r_o_min_upd;
    logic              r_o_max_upd;
    logic [MV_W-1:0]   r_o_low;
    logic [MV_W-1:0]   r_o_high;

    logic              accept;
    logic              slot_last;
    logic [SUM_W-1:0]  a_total;
    logic [AVG_Y_W-1:0] avg_y;
    logic [AVG_P_W-1:0] avg_p;
    logic [AVG_Q_W-1:0] avg_q;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              q_bit;
    logic [DEN_W-1:0]  dr_next;
    logic [CIDX_W-1:0] seg_sel;
    logic [MV_W-1:0]   c0;
    logic [MV_W-1:0]   c1;
    logic [PCT_W-1:0]  p0;
    logic [PCT_W-1:0]  p1;
    logic [MV_W-1:0]   c_den;
    logic [PCT_W-1:0]  c_dp;
    logic [MV_W-1:0]   c_off;
    logic [MV_W+PCT_W-1:0] c_prod;
    logic [NUM_W-1:0]  c_num;
    logic [MV_W-1:0]   l_den;
    logic [MV_W-1:0]   l_off;
    logic [NUM_W-1:0]  l_prod;
    logic [NUM_W-1:0]  l_num;
    logic              l_zero;
    logic [BLEND_W-1:0] blend;
    logic [T_W-1:0]    lvl_t;
    logic [P_W-1:0]    lvl_p;
    logic [P_W-blg_pkg::RECIP_SHIFT-1:0] lvl_q;
    logic [LVL_W-1:0]  level;

    assign o_ready          = (r_state == S_IDLE);
    assign accept           = i_valid && o_ready;
    assign slot_last        = (r_slot == IDX_W'(blg_pkg::RING_DEPTH - 1));
    assign o_valid          = r_o_valid;
    assign o_level_percent  = r_o_level;
    assign o_reported_mv    = r_o_rep;
    assign o_min_updated    = r_o_min_upd;
    assign o_max_updated    = r_o_max_upd;
    assign o_learned_min_mv = r_o_low;
    assign o_learned_max_mv = r_o_high;

    assign a_total = r_acc + SUM_W'(r_rd) + SUM_W'(blg_pkg::RING_DEPTH / 2);

    assign avg_y = r_acc[SUM_W-1:blg_pkg::AVG_PRE_SHIFT];
    assign avg_p = AVG_P_W'(avg_y) * AVG_P_W'(blg_pkg::AVG_RECIP);
    assign avg_q = avg_p[AVG_P_W-1:blg_pkg::AVG_RECIP_SHIFT];

    // One restoring division step per cycle.
    assign trial   = {r_dr, r_dq[NUM_W-1]};
    assign diff    = trial - {1'b0, r_dd};
    assign q_bit   = (trial >= {1'b0, r_dd});
    assign dr_next = q_bit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

    always_comb begin
        seg_sel = '0;
        for (int i = 0; i < blg_pkg::CURVE_POINTS - 1; i++) begin
            if (r_rep >= blg_pkg::curve_mv(CIDX_W'(i)) &&
                r_rep < blg_pkg::curve_mv(CIDX_W'(i + 1))) begin
                seg_sel = CIDX_W'(i);
            end
        end
    end

    assign c0     = blg_pkg::curve_mv(r_seg);
    assign c1     = blg_pkg::curve_mv(CIDX_W'(r_seg + CIDX_W'(1)));
    assign p0     = blg_pkg::curve_pct(r_seg);
    assign p1     = blg_pkg::curve_pct(CIDX_W'(r_seg + CIDX_W'(1)));
    assign c_den  = c1 - c0;
    assign c_dp   = (p1 >= p0) ? (p1 - p0) : '0;
    assign c_off  = r_rep - c0;
    assign c_prod = (MV_W + PCT_W)'(c_off) * (MV_W + PCT_W)'(c_dp);
    assign c_num  = (NUM_W'(c_prod) << blg_pkg::Q_FRAC) + NUM_W'(c_den >> 1);

    assign l_den  = r_high - r_low;
    assign l_off  = r_rep - r_low;
    assign l_prod = NUM_W'(l_off) * NUM_W'(blg_pkg::FULL_Q8);
    assign l_num  = l_prod + NUM_W'(l_den >> 1);
    assign l_zero = (r_high <= r_low) || (r_rep <= r_low);

    assign blend = BLEND_W'(r_curve) * BLEND_W'(blg_pkg::CURVE_WEIGHT)
                 + BLEND_W'(r_learn) * BLEND_W'(blg_pkg::LEARN_WEIGHT)
                 + BLEND_W'(blg_pkg::LEVEL_HALF);
    assign lvl_t = blend[BLEND_W-1:blg_pkg::LEVEL_SHIFT];
    assign lvl_p = P_W'(lvl_t) * P_W'(blg_pkg::RECIP_MUL);
    assign lvl_q = lvl_p[P_W-1:blg_pkg::RECIP_SHIFT];
    assign level = (lvl_q > (P_W - blg_pkg::RECIP_SHIFT)'(blg_pkg::LVL_MAX)) ?
                   LVL_W'(blg_pkg::LVL_MAX) : LVL_W'(lvl_q);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ring[r_slot] <= i_voltage_mv;
        end
        if (r_cnt < CNT_W'(blg_pkg::RING_DEPTH)) begin
            r_rd <= r_ring[r_cnt[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_slot    <= '0;
            r_full    <= 1'b0;
            r_first   <= 1'b0;
            r_cnt     <= '0;
            r_dcnt    <= '0;
            r_low     <= MV_W'(blg_pkg::LOW_MARK_RST);
            r_high    <= MV_W'(blg_pkg::HIGH_MARK_RST);
            r_o_valid <= 1'b0;
        end else begin
            if (r_dcnt != '0) begin
                r_dq   <= {r_dq[NUM_W-2:0], q_bit};
                r_dr   <= dr_next;
                r_dcnt <= r_dcnt - DCNT_W'(1);
            end
            if (r_o_valid && i_ready && r_state != S_FIN) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_slot <= slot_last ? '0 : r_slot + IDX_W'(1);
                        if (slot_last) begin
                            r_full <= 1'b1;
                        end
                        if (!r_first) begin
                            r_first <= 1'b1;
                            r_rep   <= i_voltage_mv;
                            r_state <= S_MARK;
                        end else if (r_full || slot_last) begin
                            r_cnt   <= '0;
                            r_acc   <= '0;
                            r_state <= S_SUM;
                        end
                    end
                end
                S_SUM: begin
                    if (r_cnt == CNT_W'(blg_pkg::RING_DEPTH)) begin
                        r_cnt   <= '0;
                        r_acc   <= a_total;
                        r_state <= S_AVG;
                    end else begin
                        if (r_cnt != '0) begin
                            r_acc <= r_acc + SUM_W'(r_rd);
                        end
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_AVG: begin
                    r_rep   <= (avg_q > AVG_Q_W'(blg_pkg::MV_MAX)) ?
                               MV_W'(blg_pkg::MV_MAX) : avg_q[MV_W-1:0];
                    r_state <= S_MARK;
                end
                S_MARK: begin
                    r_min_upd <= (r_rep < r_low);
                    r_max_upd <= (r_rep > r_high);
                    if (r_rep < r_low) begin
                        r_low <= r_rep;
                    end
                    if (r_rep > r_high) begin
                        r_high <= r_rep;
                    end
                    r_seg <= seg_sel;
                    if (r_rep <= blg_pkg::curve_mv('0)) begin
                        r_curve <= '0;
                        r_state <= S_LLOAD;
                    end else if (r_rep >= blg_pkg::curve_mv(
                                     CIDX_W'(blg_pkg::CURVE_POINTS - 1))) begin
                        r_curve <= Q_W'(blg_pkg::FULL_Q8);
                        r_state <= S_LLOAD;
                    end else begin
                        r_state <= S_CLOAD;
                    end
                end
                S_CLOAD: begin
                    r_curve <= Q_W'(p0) << blg_pkg::Q_FRAC;
                    r_dq    <= c_num << (NUM_W - blg_pkg::CURVE_N);
                    r_dr    <= '0;
                    r_dd    <= c_den;
                    r_dcnt  <= DCNT_W'(blg_pkg::CURVE_N);
                    r_state <= S_CDIV;
                end
                S_CDIV: begin
                    if (r_dcnt == '0) begin
                        r_curve <= r_curve + r_dq[Q_W-1:0];
                        r_state <= S_LLOAD;
                    end
                end
                S_LLOAD: begin
                    if (l_zero) begin
                        r_learn <= '0;
                        r_state <= S_FIN;
                    end else begin
                        r_dq    <= l_num << (NUM_W - blg_pkg::LEARN_N);
                        r_dr    <= '0;
                        r_dd    <= l_den;
                        r_dcnt  <= DCNT_W'(blg_pkg::LEARN_N);
                        r_state <= S_LDIV;
                    end
                end
                S_LDIV: begin
                    if (r_dcnt == '0) begin
                        r_learn <= (r_dq > NUM_W'(blg_pkg::FULL_Q8)) ?
                                   Q_W'(blg_pkg::FULL_Q8) : r_dq[Q_W-1:0];
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_o_valid || i_ready) begin
                        r_o_valid   <= 1'b1;
                        r_o_level   <= level;
                        r_o_rep     <= r_rep;
                        r_o_min_upd <= r_min_upd;
                        r_o_max_upd <= r_max_upd;
                        r_o_low     <= r_low;
                        r_o_high    <= r_high;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/blg_checker.sv -----
// Port-level assertions for the battery level gauge and their binding.
module blg_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_ready,
    input logic [blg_pkg::MV_W-1:0]  i_voltage_mv,
    input logic                      o_valid,
    input logic                      i_ready,
    input logic [blg_pkg::LVL_W-1:0] o_level_percent,
    input logic [blg_pkg::MV_W-1:0]  o_reported_mv,
    input logic                      o_min_updated,
    input logic                      o_max_updated,
    input logic [blg_pkg::MV_W-1:0]  o_learned_min_mv,
    input logic [blg_pkg::MV_W-1:0]  o_learned_max_mv
);

    // A waiting input word keeps its voltage until it is taken.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_voltage_mv))
        else $error("input word changed while waiting");

    // A stalled result word keeps its level and voltage.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_level_percent) &&
        $stable(o_reported_mv))
        else $error("result word changed while stalled");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_level_percent <= blg_pkg::LVL_W'(blg_pkg::LVL_MAX))
        else $error("level above full scale");

    // The reported voltage always lies inside the learned window.
    a_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_learned_min_mv <= o_reported_mv &&
        o_reported_mv <= o_learned_max_mv)
        else $error("reported voltage outside learned window");

    a_min_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_min_updated |-> o_learned_min_mv == o_reported_mv &&
        !o_max_updated)
        else $error("minimum flag without matching minimum");

endmodule

bind battery_level_gauge blg_checker u_blg_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_ready          (o_ready),
    .i_voltage_mv     (i_voltage_mv),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_level_percent  (o_level_percent),
    .o_reported_mv    (o_reported_mv),
    .o_min_updated    (o_min_updated),
    .o_max_updated    (o_max_updated),
    .o_learned_min_mv (o_learned_min_mv),
    .o_learned_max_mv (o_learned_max_mv)
);
